// ----- rtl/gnt_pkg.sv -----
// ----------------------------------------------------------------------------
// gnt_pkg
// Shared types and constants of the gradient noise turbulence block.
// ----------------------------------------------------------------------------
package gnt_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int GRAD_BITS   = 16;
   localparam int TBL_DEPTH   = 256;
   localparam int TBL_AW      = 8;
   localparam int MAX_OCTAVES = 16;
   localparam int OCT_W       = 4;
   localparam int CNT_W       = 5;

   // Input item kinds
   localparam logic [1:0] KIND_LOAD_GRAD = 2'd0;
   localparam logic [1:0] KIND_LOAD_PERM = 2'd1;
   localparam logic [1:0] KIND_EVAL      = 2'd2;

   // Permutation table selects
   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;

   // Register indexes
   localparam logic [3:0] REG_OCTAVE_COUNT    = 4'd0;
   localparam logic [3:0] REG_ABSOLUTE_RESULT = 4'd1;

   localparam logic [CNT_W-1:0] OCTAVE_COUNT_RST = 5'd7;

   typedef struct packed {
      logic       table_wr;
      logic       load_coords;
      logic       setup;
      logic       perm_hi;
      logic       latch_lo;
      logic       latch_hi;
      logic       issue;
      logic [2:0] corner;
      logic       oct_add;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic last_oct;
      logic no_oct;
      logic out_busy;
   } status_type;

endpackage

// ----- rtl/gnt_ram.sv -----
// ----------------------------------------------------------------------------
// gnt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module gnt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// gnt_ctrl
// Sequencer: octave setup, permutation reads, corner issue, drain, output.
// ----------------------------------------------------------------------------
module gnt_ctrl
   import gnt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_kind,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SETUP  = 4'd1;
   localparam logic [3:0] ST_PERM0  = 4'd2;
   localparam logic [3:0] ST_PERM1  = 4'd3;
   localparam logic [3:0] ST_PERM2  = 4'd4;
   localparam logic [3:0] ST_CORNER = 4'd5;
   localparam logic [3:0] ST_DRAIN  = 4'd6;
   localparam logic [3:0] ST_OCT    = 4'd7;
   localparam logic [3:0] ST_FINAL  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [2:0] corner_ff, corner_in;
   logic [1:0] drain_ff, drain_in;
   logic       beat;

   assign req_tready = (state_ff == ST_IDLE);
   assign beat       = req_tvalid && req_tready;

   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      drain_in  = drain_ff;
      cmd       = '0;
      cmd.table_wr = beat;
      cmd.corner   = corner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (beat && (req_kind == KIND_EVAL)) begin
               cmd.load_coords = 1'b1;
               state_in = status.no_oct ? ST_FINAL : ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_PERM0;
         end
         ST_PERM0: begin
            state_in = ST_PERM1;
         end
         ST_PERM1: begin
            cmd.perm_hi  = 1'b1;
            cmd.latch_lo = 1'b1;
            state_in     = ST_PERM2;
         end
         ST_PERM2: begin
            cmd.latch_hi = 1'b1;
            corner_in    = '0;
            state_in     = ST_CORNER;
         end
         ST_CORNER: begin
            cmd.issue = 1'b1;
            corner_in = corner_ff + 3'd1;
            if (corner_ff == 3'd7) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd3) begin
               state_in = ST_OCT;
            end
         end
         ST_OCT: begin
            cmd.oct_add = 1'b1;
            state_in = status.last_oct ? ST_FINAL : ST_SETUP;
         end
         ST_FINAL: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         corner_ff <= '0;
         drain_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
         drain_ff  <= drain_in;
      end
   end

`ifndef SYNTH
   a_eval_blocks: assert property (@(posedge clock) disable iff (reset)
      (beat && (req_kind == KIND_EVAL)) |=> !req_tready)
      else $error("input taken during evaluation");
   a_corner_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORNER && corner_ff == 3'd7) |=> (state_ff == ST_DRAIN))
      else $error("corner issue did not end after eight corners");
   a_oct_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OCT) |-> ($past(state_ff) == ST_DRAIN && $past(drain_ff) == 2'd3))
      else $error("octave sum taken before pipeline drained");
`endif

endmodule

// ----- rtl/gnt_dpath.sv -----
// ----------------------------------------------------------------------------
// gnt_dpath
// Tables, fade lanes, corner pipeline, accumulators, config and output reg.
// ----------------------------------------------------------------------------
module gnt_dpath
   import gnt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [1:0]          req_kind,
   input  logic [1:0]          req_table_select,
   input  logic [7:0]          req_index,
   input  logic signed [15:0]  req_grad_x,
   input  logic signed [15:0]  req_grad_y,
   input  logic signed [15:0]  req_grad_z,
   input  logic [7:0]          req_perm_entry,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   input  logic signed [31:0]  req_coord_z,
   input  logic                csr_beat,
   input  logic [3:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic signed [19:0]  noise_value
);

   // config
   logic [CNT_W-1:0] oct_cnt_ff;
   logic             abs_ff;
   logic [CNT_W-1:0] n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cnt_ff <= OCTAVE_COUNT_RST;
         abs_ff     <= 1'b1;
      end else if (csr_beat) begin
         if (csr_index == REG_OCTAVE_COUNT) begin
            oct_cnt_ff <= csr_data[CNT_W-1:0];
         end else if (csr_index == REG_ABSOLUTE_RESULT) begin
            abs_ff <= csr_data[0];
         end
      end
   end

   assign n_eff = (oct_cnt_ff > CNT_W'(MAX_OCTAVES)) ? CNT_W'(MAX_OCTAVES) : oct_cnt_ff;

   // tables
   logic [7:0]  perm_wr_data;
   logic [7:0]  perm_rd_addr [3];
   logic [7:0]  perm_rd_data [3];
   logic        perm_we [3];
   logic [7:0]  grad_rd_addr;
   logic [47:0] grad_rd_data;
   logic        grad_we;

   assign grad_we      = cmd.table_wr && (req_kind == KIND_LOAD_GRAD);
   assign perm_wr_data = req_perm_entry;
   assign perm_we[0] = cmd.table_wr && (req_kind == KIND_LOAD_PERM) && (req_table_select == SEL_X);
   assign perm_we[1] = cmd.table_wr && (req_kind == KIND_LOAD_PERM) && (req_table_select == SEL_Y);
   assign perm_we[2] = cmd.table_wr && (req_kind == KIND_LOAD_PERM) && (req_table_select == SEL_Z);

   gnt_ram #(.WIDTH(48), .DEPTH(TBL_DEPTH)) u_grad (
      .clock   (clock),
      .wr_en   (grad_we),
      .wr_addr (req_index),
      .wr_data ({req_grad_z, req_grad_y, req_grad_x}),
      .rd_addr (grad_rd_addr),
      .rd_data (grad_rd_data)
   );

   for (genvar a = 0; a < 3; a++) begin : g_perm
      gnt_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_perm (
         .clock   (clock),
         .wr_en   (perm_we[a]),
         .wr_addr (req_index),
         .wr_data (perm_wr_data),
         .rd_addr (perm_rd_addr[a]),
         .rd_data (perm_rd_data[a])
      );
   end

   // point, octave, cell and fraction
   logic signed [31:0] coord_ff [3];
   logic [OCT_W-1:0]   oct_ff;
   logic [7:0]         cell_ff [3];
   logic [15:0]        frac_ff [3];
   logic [7:0]         p0_ff [3];
   logic [7:0]         p1_ff [3];
   logic [31:0]        sq_ff [3];
   logic [34:0]        pm_ff [3];
   logic [16:0]        fade_ff [3];
   logic [47:0]        shifted [3];
   logic [32:0]        sq_rnd [3];
   logic [16:0]        t2 [3];
   logic [17:0]        kf [3];
   logic [35:0]        pm_rnd [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         shifted[a]      = {16'd0, coord_ff[a]} << oct_ff;
         perm_rd_addr[a] = cell_ff[a] + {7'd0, cmd.perm_hi};
         sq_rnd[a]       = {1'b0, sq_ff[a]} + 33'd32768;
         t2[a]           = sq_rnd[a][32:16];
         kf[a]           = 18'd196608 - {1'b0, frac_ff[a], 1'b0};
         pm_rnd[a]       = {1'b0, pm_ff[a]} + 36'd32768;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (cmd.setup) begin
            cell_ff[a] <= shifted[a][23:16];
            frac_ff[a] <= shifted[a][15:0];
         end
         if (cmd.latch_lo) begin
            p0_ff[a] <= perm_rd_data[a];
         end
         if (cmd.latch_hi) begin
            p1_ff[a] <= perm_rd_data[a];
         end
         // fade lanes run freely off the held fraction
         sq_ff[a]   <= frac_ff[a] * frac_ff[a];
         pm_ff[a]   <= t2[a] * kf[a];
         fade_ff[a] <= pm_rnd[a][32:16];
      end
      if (cmd.load_coords) begin
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
      end
   end

   // gradient index of the corner being issued
   assign grad_rd_addr = (cmd.corner[2] ? p1_ff[0] : p0_ff[0]) ^
                         (cmd.corner[1] ? p1_ff[1] : p0_ff[1]) ^
                         (cmd.corner[0] ? p1_ff[2] : p0_ff[2]);

   // corner pipeline
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]         k1_ff, k2_ff;
   logic signed [17:0] dvec [3];
   logic [16:0]        wvec [3];
   logic signed [15:0] gvec [3];
   logic signed [33:0] m_ff [3];
   logic [33:0]        wxy_ff;
   logic signed [35:0] dsum;
   logic signed [35:0] dsum_rnd;
   logic signed [21:0] dot_ff;
   logic [34:0]        wxy_rnd;
   logic [16:0]        wr;
   logic [16:0]        wz2;
   logic [33:0]        wp_ff;
   logic [34:0]        wp_rnd;
   logic [16:0]        wt;
   logic signed [39:0] prod_ff;
   logic signed [39:0] prod_rnd;
   logic signed [27:0] noise_ff;
   logic signed [31:0] acc_ff;

   assign gvec[0] = $signed(grad_rd_data[15:0]);
   assign gvec[1] = $signed(grad_rd_data[31:16]);
   assign gvec[2] = $signed(grad_rd_data[47:32]);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dvec[a] = $signed({2'b00, frac_ff[a]}) - (k1_ff[2-a] ? 18'sd65536 : 18'sd0);
         wvec[a] = k1_ff[2-a] ? fade_ff[a] : (17'd65536 - fade_ff[a]);
      end
      dsum     = 36'(m_ff[0]) + 36'(m_ff[1]) + 36'(m_ff[2]);
      dsum_rnd = dsum + 36'sd8192;
      wxy_rnd  = {1'b0, wxy_ff} + 35'd32768;
      wr       = wxy_rnd[32:16];
      wz2      = k2_ff[0] ? fade_ff[2] : (17'd65536 - fade_ff[2]);
      wp_rnd   = {1'b0, wp_ff} + 35'd32768;
      wt       = wp_rnd[32:16];
      prod_rnd = prod_ff + 40'sd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      k1_ff <= cmd.corner;
      k2_ff <= k1_ff;
      for (int a = 0; a < 3; a++) begin
         m_ff[a] <= gvec[a] * dvec[a];
      end
      wxy_ff  <= wvec[0] * wvec[1];
      dot_ff  <= dsum_rnd[35:14];
      wp_ff   <= wr * wz2;
      prod_ff <= $signed({1'b0, wt}) * dot_ff;
   end

   // octave and turbulence sums
   logic signed [31:0] noise_ext;
   logic signed [31:0] half;
   logic signed [31:0] oct_term;
   logic [CNT_W-1:0]   oct_next;

   assign noise_ext = 32'(noise_ff);
   assign half      = (oct_ff == '0) ? 32'sd0 : (32'sd1 <<< (oct_ff - OCT_W'(1)));
   assign oct_term  = (noise_ext + half) >>> oct_ff;
   assign oct_next  = {1'b0, oct_ff} + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         noise_ff <= '0;
      end else if (v4_ff) begin
         noise_ff <= noise_ff + 28'($signed(prod_rnd[39:16]));
      end
      if (cmd.load_coords) begin
         acc_ff <= '0;
         oct_ff <= '0;
      end else if (cmd.oct_add) begin
         acc_ff <= acc_ff + oct_term;
         oct_ff <= oct_next[OCT_W-1:0];
      end
   end

   // result: optional magnitude, then saturation
   logic signed [31:0] mag;
   logic signed [19:0] sat;
   logic               rsp_valid_ff;
   logic signed [19:0] rsp_data_ff;

   always_comb begin
      mag = (abs_ff && acc_ff < 0) ? -acc_ff : acc_ff;
      if (mag > 32'sd524287) begin
         sat = 20'sd524287;
      end else if (mag < -32'sd524288) begin
         sat = -20'sd524288;
      end else begin
         sat = mag[19:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= sat;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign noise_value = rsp_data_ff;

   assign status.last_oct = (oct_next == n_eff);
   assign status.no_oct   = (n_eff == '0);
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

endmodule

// ----- rtl/gradient_noise_turbulence_top.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_turbulence_top
// 3D gradient noise with octave turbulence over loadable tables.
// ----------------------------------------------------------------------------
//  channel  direction  ports                           contents
//  req      in         req_tvalid/tready/tdata/tuser   table loads, eval points
//  rsp      out        rsp_tvalid/tready/tdata         noise_value Q3.16
//  csr      in         csr_valid/ready/index/data      octave_count, abs flag
//
//  Load beats finish in the cycle they are taken. An evaluate beat runs,
//  for each of n octaves (n the octave count clamped to 16; 0 runs none),
//  a setup, permutation table reads (two reads per table), 8 gradient
//  reads, corner pipeline drain and an octave add, then loads the output.
//  Reset is synchronous; tables are not cleared and read as garbage until
//  loaded. The result sits in an output register, so a new beat is taken
//  while rsp is stalled; a finished sum waits only if that register is full.
// ----------------------------------------------------------------------------
module gradient_noise_turbulence_top
   import gnt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // req_tuser: kind[1:0], table_select[3:2]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [3:0]   req_tuser,
   // req_tdata: index[7:0], grad_x[23:8], grad_y[39:24], grad_z[55:40],
   //            perm_entry[63:56], coord_x[95:64], coord_y[127:96],
   //            coord_z[159:128]
   input  logic [159:0] req_tdata,
   // rsp_tdata: noise_value[19:0], zero fill [23:20]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_index,
   input  logic [31:0]  csr_data
);

   cmd_type            cmd;
   status_type         status;
   logic signed [19:0] noise_value;

   // registers are always writable
   assign csr_ready = 1'b1;

   gnt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser[1:0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gnt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_tuser[1:0]),
      .req_table_select (req_tuser[3:2]),
      .req_index        (req_tdata[7:0]),
      .req_grad_x       ($signed(req_tdata[23:8])),
      .req_grad_y       ($signed(req_tdata[39:24])),
      .req_grad_z       ($signed(req_tdata[55:40])),
      .req_perm_entry   (req_tdata[63:56]),
      .req_coord_x      ($signed(req_tdata[95:64])),
      .req_coord_y      ($signed(req_tdata[127:96])),
      .req_coord_z      ($signed(req_tdata[159:128])),
      .csr_beat         (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .noise_value      (noise_value)
   );

   assign rsp_tdata = {4'd0, noise_value};

endmodule

// ----- tb/tb_gradient_noise_turbulence_top.sv -----
// ----------------------------------------------------------------------------
// tb_gradient_noise_turbulence_top
// Stream-level check of the turbulence block: fills the gradient and
// permutation tables, evaluates points under several octave and sign
// settings, and compares each noise value against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_gradient_noise_turbulence_top;
   import gnt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   typedef struct packed {
      logic [3:0]   tuser;
      logic [159:0] tdata;
   } beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [3:0]   req_tuser = '0;
   logic [159:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [3:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   gradient_noise_turbulence_top DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: shadow tables and registers
   longint    grad_tbl [256][3];
   bit [7:0]  px [256], py [256], pz [256];
   bit [4:0]  oct_cnt = 5'd7;
   bit        abs_mode = 1'b1;

   beat_type      pending_beats [$];
   logic [19:0]   expected_noise [$];
   int            failures = 0;
   int            results_seen = 0;
   int            evals_sent = 0;
   int            idle_cycles = 0;
   bit            long_hold = 1'b0;
   bit            req_wait = 1'b0;

   // floor-based round half up of x / 2^s
   function automatic longint rnd(longint x, int s);
      if (s == 0) return x;
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint fade_of(longint t);
      longint t2;
      t2 = rnd(t * t, FRAC_BITS);
      return rnd(t2 * (3 * 65536 - 2 * t), FRAC_BITS);
   endfunction

   function automatic longint octave_sum(longint c [3], int o);
      longint fr [3], fd [3], acc, w, dt, dx, dy, dz, wx, wy, wz;
      int     cl [3];
      bit [63:0] sh;
      bit [7:0]  g;
      acc = 0;
      for (int a = 0; a < 3; a++) begin
         sh = 64'(c[a]) << o;
         cl[a] = int'(sh[23:16]);
         fr[a] = longint'({48'd0, sh[15:0]});
         fd[a] = fade_of(fr[a]);
      end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               g  = px[8'(cl[0] + i)] ^ py[8'(cl[1] + j)] ^ pz[8'(cl[2] + k)];
               dx = fr[0] - (i ? 65536 : 0);
               dy = fr[1] - (j ? 65536 : 0);
               dz = fr[2] - (k ? 65536 : 0);
               wx = i ? fd[0] : 65536 - fd[0];
               wy = j ? fd[1] : 65536 - fd[1];
               wz = k ? fd[2] : 65536 - fd[2];
               w  = rnd(rnd(wx * wy, FRAC_BITS) * wz, FRAC_BITS);
               dt = rnd(grad_tbl[g][0] * dx + grad_tbl[g][1] * dy
                        + grad_tbl[g][2] * dz, GRAD_BITS - 2);
               acc += rnd(w * dt, FRAC_BITS);
            end
      return acc;
   endfunction

   // Applies one accepted request beat to the shadow state
   task automatic predict_noise(beat_type b);
      logic [1:0] kind, sel;
      logic [7:0] idx;
      longint c [3], acc;
      int n;
      kind = b.tuser[1:0];
      sel  = b.tuser[3:2];
      idx  = b.tdata[7:0];
      if (kind == KIND_LOAD_GRAD) begin
         grad_tbl[idx][0] = longint'($signed(b.tdata[23:8]));
         grad_tbl[idx][1] = longint'($signed(b.tdata[39:24]));
         grad_tbl[idx][2] = longint'($signed(b.tdata[55:40]));
      end else if (kind == KIND_LOAD_PERM) begin
         if (sel == SEL_X) px[idx] = b.tdata[63:56];
         else if (sel == SEL_Y) py[idx] = b.tdata[63:56];
         else if (sel == SEL_Z) pz[idx] = b.tdata[63:56];
      end else if (kind == KIND_EVAL) begin
         c[0] = longint'($signed(b.tdata[95:64]));
         c[1] = longint'($signed(b.tdata[127:96]));
         c[2] = longint'($signed(b.tdata[159:128]));
         n = (oct_cnt > MAX_OCTAVES) ? MAX_OCTAVES : oct_cnt;
         acc = 0;
         for (int o = 0; o < n; o++) acc += rnd(octave_sum(c, o), o);
         if (abs_mode && acc < 0) acc = -acc;
         if (acc > 524287) acc = 524287;
         if (acc < -524288) acc = -524288;
         expected_noise.push_back(acc[19:0]);
      end
   endtask

   // Offered beat still waiting after the last rising edge
   always @(posedge clock) begin
      req_wait <= req_tvalid && !req_tready;
   end

   // Driver: bursts of beats separated by random gaps
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_wait) begin
            // hold the offered beat
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            {req_tuser, req_tdata} <= pending_beats.pop_front();
            req_tvalid <= 1'b1;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern; long_hold forces a stretch of back-pressure
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (long_hold) rsp_tready <= 1'b0;
      else if (stall_phase[8]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   // Monitor: predicts on accepted requests, checks accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_noise({req_tuser, req_tdata});
            idle_cycles <= 0;
         end else if (rsp_tvalid && rsp_tready) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (expected_noise.size() == 0) begin
               $error("noise_value: unexpected result %0d",
                      $signed(rsp_tdata[19:0]));
               failures <= failures + 1;
            end else begin
               if (rsp_tdata[19:0] !== expected_noise[0]) begin
                  $error("noise_value: expected %0d actual %0d",
                         $signed(expected_noise[0]), $signed(rsp_tdata[19:0]));
                  failures <= failures + 1;
               end
               void'(expected_noise.pop_front());
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (idle_cycles > WATCHDOG_LIMIT && !long_hold) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("tb_gradient_noise_turbulence_top NOT OK");
         $finish;
      end
   end

   function automatic beat_type grad_beat(bit [7:0] idx, bit [15:0] gx, bit [15:0] gy,
                                          bit [15:0] gz);
      beat_type b;
      b.tuser = {2'd0, KIND_LOAD_GRAD};
      b.tdata = '0;
      b.tdata[159:56] = {$urandom(), $urandom(), $urandom(), 8'($urandom())};
      b.tdata[55:0] = {gz, gy, gx, idx};
      return b;
   endfunction

   function automatic beat_type perm_beat(bit [1:0] sel, bit [7:0] idx, bit [7:0] v);
      beat_type b;
      b.tuser = {sel, KIND_LOAD_PERM};
      b.tdata = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      b.tdata[7:0] = idx;
      b.tdata[63:56] = v;
      return b;
   endfunction

   function automatic beat_type eval_beat(bit [31:0] x, bit [31:0] y, bit [31:0] z);
      beat_type b;
      b.tuser = {2'($urandom()), KIND_EVAL};
      b.tdata = {z, y, x, $urandom(), $urandom()};
      return b;
   endfunction

   function automatic bit [15:0] rand_grad();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // Random coordinate, mostly small magnitudes, sometimes full range
   function automatic bit [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
         default: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      endcase
   endfunction

   task automatic csr_write(logic [3:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_OCTAVE_COUNT) oct_cnt = val[4:0];
      else if (idx == REG_ABSOLUTE_RESULT) abs_mode = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits for all queued beats to be taken and all results returned
   task automatic drain();
      while (pending_beats.size() > 0 || req_tvalid || expected_noise.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_random_evals(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: pending_beats.push_back(grad_beat(8'($urandom()), rand_grad(),
                                                 rand_grad(), rand_grad()));
            1: pending_beats.push_back(perm_beat(2'($urandom_range(0, 2)),
                                                 8'($urandom()), 8'($urandom())));
            default: begin
               pending_beats.push_back(eval_beat(rand_coord(), rand_coord(),
                                                 rand_coord()));
               evals_sent++;
            end
         endcase
      end
   endtask

   initial begin
      bit [4:0] oct_settings [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full table fill so no evaluation can touch an unwritten entry
      for (int i = 0; i < 256; i++) begin
         pending_beats.push_back(grad_beat(8'(i), rand_grad(), rand_grad(), rand_grad()));
         for (int s = 0; s < 3; s++)
            pending_beats.push_back(perm_beat(2'(s), 8'(i), 8'($urandom())));
      end
      drain();

      // Directed: gradient extremes, ignored kinds/selects, corner points
      pending_beats.push_back(grad_beat(8'd0, 16'hC000, 16'h4000, 16'hC000));
      pending_beats.push_back(grad_beat(8'd255, 16'h4000, 16'hC000, 16'h4000));
      pending_beats.push_back(perm_beat(2'd3, 8'd5, 8'hFF));
      begin
         beat_type b;
         b = eval_beat(0, 0, 0);
         b.tuser[1:0] = 2'd3;
         pending_beats.push_back(b);
      end
      pending_beats.push_back(perm_beat(SEL_X, 8'd0, 8'd0));
      pending_beats.push_back(perm_beat(SEL_Z, 8'd255, 8'd255));
      pending_beats.push_back(eval_beat(32'h0, 32'h0, 32'h0));
      pending_beats.push_back(eval_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_beats.push_back(eval_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      pending_beats.push_back(eval_beat(32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_0000));
      pending_beats.push_back(eval_beat(32'h0000_7FFF, 32'hFFFF_0000, 32'h00FF_FFFF));
      pending_beats.push_back(eval_beat(32'h0000_C000, 32'h0000_4000, 32'hFFFF_8000));
      evals_sent += 6;
      drain();

      // Random phases across octave and sign settings; one phase holds
      // the receiver off long enough to back up the request side
      for (int p = 0; p < 6; p++) begin
         csr_write(REG_OCTAVE_COUNT, {$urandom() & 32'hFFFF_FFE0} | oct_settings[p]);
         csr_write(REG_ABSOLUTE_RESULT, {31'($urandom()), p[0]});
         if (p == 2) csr_write(4'd9, $urandom());
         queue_random_evals(p == 1 ? 40 : 85);
         if (p == 4) begin
            long_hold = 1'b1;
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end
         drain();
      end

      $display("covered %0d evaluations, %0d results, octave counts 0..31, both sign modes",
               evals_sent, results_seen);
      if (failures == 0 && expected_noise.size() == 0)
         $display("tb_gradient_noise_turbulence_top OK");
      else
         $display("tb_gradient_noise_turbulence_top NOT OK");
      $finish;
   end

endmodule

// ----- gradient_noise_turbulence_top.f -----
rtl/gnt_pkg.sv
rtl/gnt_ram.sv
rtl/gnt_ctrl.sv
rtl/gnt_dpath.sv
rtl/gradient_noise_turbulence_top.sv
tb/tb_gradient_noise_turbulence_top.sv
